[src/dxt5_pkg.sv]
// ----------------------------------------------------------------------------
// dxt5_pkg
// Shared types, constants and arithmetic helpers for the DXT5 block decoder.
// ----------------------------------------------------------------------------
package dxt5_pkg;

  localparam int unsigned TexelCount = 16;
  localparam int unsigned QueueDepth = 2;

  // Reciprocal constants for exact truncating division of sums below 2048
  localparam logic [24:0] Recip7 = 25'd2341;
  localparam logic [24:0] Recip5 = 25'd3277;
  localparam logic [24:0] Recip3 = 25'd5462;
  localparam int unsigned RecipShift = 14;

  typedef logic [23:0] rgb_t;

  // One decoded block: both palettes plus the per-texel indices
  typedef struct packed {
    logic [7:0][7:0]  alpha_pal;
    logic [3:0][23:0] color_pal;
    logic [15:0][2:0] alpha_idx;
    logic [15:0][1:0] color_idx;
  } block_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Weighted sum of two 8-bit values with 3-bit weights
  function automatic logic [10:0] wsum(input logic [7:0] a0, input logic [7:0] a1,
                                       input logic [2:0] w0, input logic [2:0] w1);
    logic [10:0] p0;
    logic [10:0] p1;
    p0 = {3'b0, a0} * {8'b0, w0};
    p1 = {3'b0, a1} * {8'b0, w1};
    return p0 + p1;
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [24:0] p;
    p = {14'b0, x} * Recip7;
    return p[RecipShift +: 8];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [24:0] p;
    p = {14'b0, x} * Recip5;
    return p[RecipShift +: 8];
  endfunction

  function automatic logic [7:0] div3(input logic [10:0] x);
    logic [24:0] p;
    p = {14'b0, x} * Recip3;
    return p[RecipShift +: 8];
  endfunction

  // Expand RGB565 to 8 bits per channel by bit replication
  function automatic rgb_t expand565(input logic [15:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {c[15:11], c[15:13]};
    g = {c[10:5], c[10:9]};
    b = {c[4:0], c[4:2]};
    return {r, g, b};
  endfunction

  // Truncated (2*a + b) / 3 per channel
  function automatic rgb_t third(input rgb_t a, input rgb_t b);
    rgb_t res;
    for (int k = 0; k < 3; k++) begin
      res[k*8 +: 8] = div3({2'b0, a[k*8 +: 8], 1'b0} + {3'b0, b[k*8 +: 8]});
    end
    return res;
  endfunction

endpackage

[src/dxt5_front.sv]
// ----------------------------------------------------------------------------
// dxt5_front
// Accepts compressed blocks, builds the alpha and color palettes and pushes
// each decoded block into the queue.
// ----------------------------------------------------------------------------
module dxt5_front import dxt5_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          block_valid,
  output logic          block_stall,
  input  logic [63:0]   alpha_half,
  input  logic [63:0]   color_half,
  input  queue_status_t q_status,
  output logic          push,
  output block_entry_t  push_entry
);

  logic        hold_valid;
  logic [63:0] hold_alpha;
  logic [63:0] hold_color;
  logic        accept;

  assign push        = hold_valid && !q_status.full;
  assign block_stall = hold_valid && !push;
  assign accept      = block_valid && !block_stall;

  // Hold the accepted block until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_alpha <= alpha_half;
      hold_color <= color_half;
    end
  end

  // Build palettes from the held block
  always_comb begin
    logic [7:0] a0;
    logic [7:0] a1;
    rgb_t       c0;
    rgb_t       c1;
    a0 = hold_alpha[7:0];
    a1 = hold_alpha[15:8];
    push_entry = '0;
    push_entry.alpha_pal[0] = a0;
    push_entry.alpha_pal[1] = a1;
    if (a0 > a1) begin
      for (int i = 1; i <= 6; i++) begin
        push_entry.alpha_pal[i + 1] = div7(wsum(a0, a1, 3'(7 - i), 3'(i)));
      end
    end else begin
      for (int i = 1; i <= 4; i++) begin
        push_entry.alpha_pal[i + 1] = div5(wsum(a0, a1, 3'(5 - i), 3'(i)));
      end
      push_entry.alpha_pal[6] = 8'd0;
      push_entry.alpha_pal[7] = 8'd255;
    end
    c0 = expand565(hold_color[15:0]);
    c1 = expand565(hold_color[31:16]);
    push_entry.color_pal[0] = c0;
    push_entry.color_pal[1] = c1;
    push_entry.color_pal[2] = third(c0, c1);
    push_entry.color_pal[3] = third(c1, c0);
    push_entry.alpha_idx    = hold_alpha[63:16];
    push_entry.color_idx    = hold_color[63:32];
  end

endmodule

[src/dxt5_queue.sv]
// ----------------------------------------------------------------------------
// dxt5_queue
// Two-entry queue of decoded blocks between the front and back parts.
// ----------------------------------------------------------------------------
module dxt5_queue import dxt5_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  block_entry_t  push_entry,
  input  logic          pop,
  output block_entry_t  head,
  output queue_status_t q_status
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  block_entry_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_status.full  = (count == CntW'(QueueDepth));
  assign q_status.empty = (count == '0);
  assign head           = mem[rd_ptr];

  // Write the incoming block
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/dxt5_back.sv]
// ----------------------------------------------------------------------------
// dxt5_back
// Walks the sixteen texels of the queue head and drives the texel output
// register, one texel per cycle while texel_stall is low and a block is queued.
// ----------------------------------------------------------------------------
module dxt5_back import dxt5_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  block_entry_t  head,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          texel_valid,
  input  logic          texel_stall,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue,
  output logic [7:0]    alpha,
  output logic [3:0]    texel_index,
  output logic          last
);

  logic [3:0] cnt;
  logic       advance;
  logic       load;
  rgb_t       color;

  assign advance = !texel_valid || !texel_stall;
  assign load    = advance && !q_status.empty;
  assign pop     = load && (cnt == 4'(TexelCount - 1));
  assign color   = head.color_pal[head.color_idx[cnt]];

  // Advance the texel counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      texel_valid <= 1'b0;
    end else if (load) begin
      cnt         <= cnt + 1'b1;
      texel_valid <= 1'b1;
    end else if (advance) begin
      texel_valid <= 1'b0;
    end
  end

  // Load the texel payload
  always_ff @(posedge clk) begin
    if (load) begin
      red         <= color[23:16];
      green       <= color[15:8];
      blue        <= color[7:0];
      alpha       <= head.alpha_pal[head.alpha_idx[cnt]];
      texel_index <= cnt;
      last        <= (cnt == 4'(TexelCount - 1));
    end
  end

endmodule

[src/dxt5_block_decoder_unit.sv]
// ----------------------------------------------------------------------------
// dxt5_block_decoder_unit
// DXT5 (BC3) block decoder: one 16-byte block in, sixteen RGBA texels out.
// ----------------------------------------------------------------------------
// Path: front hold register, then queue entry, then texel output register.
// Throughput: one texel per cycle while texel_stall is low, set by the
//   single texel output port; a two-block queue decouples input and output.
// Reset: synchronous; clears valid flags, queue pointers and texel counter.
//   No clearing pass; blocks are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module dxt5_block_decoder_unit import dxt5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        block_valid,
  output logic        block_stall,
  input  logic [63:0] alpha_half,
  input  logic [63:0] color_half,
  output logic        texel_valid,
  input  logic        texel_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [3:0]  texel_index,
  output logic        last
);

  logic          push;
  logic          pop;
  block_entry_t  push_entry;
  block_entry_t  head;
  queue_status_t q_status;

  dxt5_front u_front (
    .clk         (clk),
    .rst         (rst),
    .block_valid (block_valid),
    .block_stall (block_stall),
    .alpha_half  (alpha_half),
    .color_half  (color_half),
    .q_status    (q_status),
    .push        (push),
    .push_entry  (push_entry)
  );

  dxt5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  dxt5_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .texel_valid (texel_valid),
    .texel_stall (texel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .texel_index (texel_index),
    .last        (last)
  );

endmodule
